[rtl/prim_mst_pkg.sv]
// Shared item types and fixed field widths for the spanning tree unit.
package prim_mst_pkg;

	localparam int VTX_W       = 5;
	localparam int WGT_W       = 16;
	localparam int COST_W      = 21;
	localparam int CFG_W       = 6;
	localparam int MAX_RESULTS = 32;

	typedef struct packed {
		logic [VTX_W-1:0] first_vertex;
		logic [VTX_W-1:0] second_vertex;
		logic [WGT_W-1:0] edge_weight;
		logic             last_edge;
	} load_item_t;

	typedef struct packed {
		logic [VTX_W-1:0]  from_vertex;
		logic [VTX_W-1:0]  to_vertex;
		logic [WGT_W-1:0]  tree_weight;
		logic [COST_W-1:0] total_cost;
		logic              is_total;
		logic              last;
	} tree_item_t;

	// Sequencer commands for the relaxation unit.
	typedef struct packed {
		logic init;   // start of a run: only the root is visited
		logic clear;  // start of a pass: forget the candidate
		logic first;  // first pass: stored keys count as no edge
		logic valid;  // a matrix word for vertex u arrives this cycle
		logic mark;   // the current candidate joins the tree
	} relax_ctl_t;

endpackage

[rtl/prim_mst_ram.sv]
// Generic single write port RAM with one registered read port.
module prim_mst_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/prim_mst_relax.sv]
// Shared key relaxation and minimum tracking unit with the key, parent and visited stores.
module prim_mst_relax #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  prim_mst_pkg::relax_ctl_t        ctl,
	input  logic [$clog2(MAX_VERTICES)-1:0] base,
	input  logic [$clog2(MAX_VERTICES)-1:0] u,
	input  logic [WEIGHT_BITS:0]            w,
	output logic                            cand_found,
	output logic [$clog2(MAX_VERTICES)-1:0] cand_vtx,
	output logic [WEIGHT_BITS:0]            cand_key,
	output logic [$clog2(MAX_VERTICES)-1:0] cand_parent
);
	import prim_mst_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int KW = WEIGHT_BITS + 1;
	localparam logic [KW-1:0] NO_EDGE = {1'b1, {WEIGHT_BITS{1'b0}}};

	logic [KW-1:0]           key_q    [MAX_VERTICES];
	logic [VW-1:0]           parent_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] visited_q;
	logic                    found_q;
	logic [VW-1:0]           cand_q;
	logic [KW-1:0]           cand_key_q;
	logic [VW-1:0]           cand_par_q;

	logic [KW-1:0] cur_key;
	logic          better;
	logic          upd;
	logic [KW-1:0] new_key;
	logic [VW-1:0] new_par;
	logic          open;
	logic          take;

	// The first pass of a run treats every key as unset, so the stores need no init sweep.
	always_comb begin
		cur_key = ctl.first ? NO_EDGE : key_q[u];
		better  = w < cur_key;
		upd     = better || ctl.first;
		new_key = better ? w : cur_key;
		new_par = upd ? base : parent_q[u];
		open    = !visited_q[u];
		// Keys equal to no edge are never candidates; strict compare keeps the lowest index.
		take    = ctl.valid && open && !new_key[KW-1] &&
		          (!found_q || (new_key < cand_key_q));
	end

	always_ff @(posedge clk) begin
		if (ctl.valid && open && upd) begin
			key_q[u]    <= new_key;
			parent_q[u] <= new_par;
		end
		if (take) begin
			cand_q     <= u;
			cand_key_q <= new_key;
			cand_par_q <= new_par;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			found_q   <= 1'b0;
		end else begin
			if (ctl.init) begin
				visited_q <= MAX_VERTICES'(1);
			end else if (ctl.mark) begin
				visited_q[cand_q] <= 1'b1;
			end
			if (ctl.clear) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	assign cand_found  = found_q;
	assign cand_vtx    = cand_q;
	assign cand_key    = cand_key_q;
	assign cand_parent = cand_par_q;

endmodule

[rtl/prim_minimum_spanning_tree_unit.sv]
// Each edge item is accepted in IDLE with the matrix read, then compared and written in
// LOAD. A last edge starts a run of rounds, one per joined vertex plus one; each round
// reads the base vertex's n entries (n the clamped vertex count) over the single matrix
// read port in PASS, then goes through WAIT, DECIDE and EMIT. After the total item all
// 4^clog2(MAX_VERTICES) matrix entries (1024 by default) are cleared, one entry a cycle,
// with no item accepted. Reset starts the same clearing pass and sets the vertex count to 32.
module prim_minimum_spanning_tree_unit #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [prim_mst_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                    load_valid,
	output logic                                    load_stall,
	input  prim_mst_pkg::load_item_t                load_item,
	output logic                                    tree_valid,
	input  logic                                    tree_stall,
	output prim_mst_pkg::tree_item_t                tree_item
);
	import prim_mst_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int KW    = WEIGHT_BITS + 1;
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int CNT_W = $clog2(MAX_RESULTS);
	localparam logic [KW-1:0] NO_EDGE = {1'b1, {WEIGHT_BITS{1'b0}}};

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_PASS   = 3'd3;
	localparam logic [2:0] ST_WAIT   = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  vcount_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     load_addr_q;
	logic [KW-1:0]     load_key_q;
	logic              load_ok_q;
	logic              load_last_q;
	logic [VW-1:0]     base_q;
	logic [VW-1:0]     idx_q;
	logic              first_q;
	logic              v_s1;
	logic [VW-1:0]     u_s1;
	logic [CNT_W-1:0]  count_q;
	logic [COST_W-1:0] cost_q;
	logic              emit_total_q;
	logic              tree_valid_q;
	tree_item_t        tree_item_q;

	logic [CFG_W-1:0]  n_act;
	logic [CFG_W-1:0]  n_last;
	logic              accept;
	logic              out_free;
	logic              edge_ok;
	logic [VTX_W-1:0]  in_lo;
	logic [VTX_W-1:0]  in_hi;
	logic [AW-1:0]     in_addr;
	logic [VW-1:0]     pass_lo;
	logic [VW-1:0]     pass_hi;
	logic [AW-1:0]     pass_addr;
	logic              idx_last;
	logic              join_ok;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [KW-1:0]     ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [KW-1:0]     ram_rdata;

	relax_ctl_t        ctl;
	logic              cand_found;
	logic [VW-1:0]     cand_vtx;
	logic [KW-1:0]     cand_key;
	logic [VW-1:0]     cand_parent;

	always_comb begin
		if (vcount_q == '0) begin
			n_act = CFG_W'(1);
		end else if (vcount_q > CFG_W'(MAX_VERTICES)) begin
			n_act = CFG_W'(MAX_VERTICES);
		end else begin
			n_act = vcount_q;
		end
		n_last = n_act - CFG_W'(1);
	end

	// Only the upper triangle of the matrix is stored: each pair lives at (low, high).
	always_comb begin
		edge_ok = (CFG_W'(load_item.first_vertex) < n_act) &&
		          (CFG_W'(load_item.second_vertex) < n_act) &&
		          (load_item.first_vertex != load_item.second_vertex);
		if (load_item.first_vertex < load_item.second_vertex) begin
			in_lo = load_item.first_vertex;
			in_hi = load_item.second_vertex;
		end else begin
			in_lo = load_item.second_vertex;
			in_hi = load_item.first_vertex;
		end
		in_addr = {VW'(in_lo), VW'(in_hi)};
		pass_lo   = (base_q < idx_q) ? base_q : idx_q;
		pass_hi   = (base_q < idx_q) ? idx_q : base_q;
		pass_addr = {pass_lo, pass_hi};
		idx_last  = CFG_W'(idx_q) == n_last;
	end

	assign accept     = load_valid && !load_stall;
	assign load_stall = state_q != ST_IDLE;
	assign out_free   = !tree_valid_q || !tree_stall;
	assign join_ok    = cand_found && (count_q != CNT_W'(MAX_RESULTS - 1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = load_addr_q;
		ram_wdata = load_key_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = NO_EDGE;
			end
			ST_LOAD: begin
				ram_we = load_ok_q && (load_key_q < ram_rdata);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_raddr = (state_q == ST_PASS) ? pass_addr : in_addr;
	end

	always_comb begin
		ctl.init  = (state_q == ST_LOAD) && load_last_q;
		ctl.clear = ctl.init || ((state_q == ST_EMIT) && out_free && !emit_total_q);
		ctl.first = first_q;
		ctl.valid = v_s1;
		ctl.mark  = (state_q == ST_DECIDE) && join_ok;
	end

	prim_mst_ram #(
		.WIDTH(KW),
		.DEPTH(DEPTH)
	) u_matrix (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	prim_mst_relax #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_relax (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.base       (base_q),
		.u          (u_s1),
		.w          (ram_rdata),
		.cand_found (cand_found),
		.cand_vtx   (cand_vtx),
		.cand_key   (cand_key),
		.cand_parent(cand_parent)
	);

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		u_s1 <= idx_q;
		if (accept) begin
			load_addr_q <= in_addr;
			load_key_q  <= {1'b0, WEIGHT_BITS'(load_item.edge_weight)};
			load_ok_q   <= edge_ok;
			load_last_q <= load_item.last_edge;
		end
		if ((state_q == ST_DECIDE) && join_ok) begin
			base_q <= cand_vtx;
		end else if ((state_q == ST_LOAD) && load_last_q) begin
			base_q <= '0;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			if (emit_total_q) begin
				tree_item_q.from_vertex <= '0;
				tree_item_q.to_vertex   <= '0;
				tree_item_q.tree_weight <= '0;
				tree_item_q.is_total    <= 1'b1;
				tree_item_q.last        <= 1'b1;
			end else begin
				tree_item_q.from_vertex <= VTX_W'(cand_parent);
				tree_item_q.to_vertex   <= VTX_W'(cand_vtx);
				tree_item_q.tree_weight <= WGT_W'(cand_key[WEIGHT_BITS-1:0]);
				tree_item_q.is_total    <= 1'b0;
				tree_item_q.last        <= 1'b0;
			end
			tree_item_q.total_cost <= cost_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			vcount_q     <= 6'd32;
			clr_q        <= '0;
			idx_q        <= '0;
			first_q      <= 1'b0;
			v_s1         <= 1'b0;
			count_q      <= '0;
			cost_q       <= '0;
			emit_total_q <= 1'b0;
			tree_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_data;
			end
			if (tree_valid_q && !tree_stall) begin
				tree_valid_q <= 1'b0;
			end
			v_s1 <= state_q == ST_PASS;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load_last_q) begin
						idx_q   <= '0;
						first_q <= 1'b1;
						count_q <= '0;
						cost_q  <= '0;
						state_q <= ST_PASS;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PASS: begin
					idx_q <= idx_q + VW'(1);
					if (idx_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					emit_total_q <= !join_ok;
					if (join_ok) begin
						cost_q  <= cost_q + COST_W'(cand_key[WEIGHT_BITS-1:0]);
						first_q <= 1'b0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						tree_valid_q <= 1'b1;
						if (emit_total_q) begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							count_q <= count_q + CNT_W'(1);
							idx_q   <= '0;
							state_q <= ST_PASS;
						end
					end
				end
				default: begin
					clr_q   <= '0;
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign tree_valid = tree_valid_q;
	assign tree_item  = tree_item_q;

	// The root is visited before the first pass, so it can never be a candidate.
	a_root_never_joins: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && cand_found |-> cand_vtx != '0)
		else $error("root vertex chosen as a joining candidate");

	a_matrix_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR) || (state_q == ST_LOAD))
		else $error("matrix written outside clearing or edge loading");

	a_pass_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> !v_s1)
		else $error("decision taken before the pass finished");

	a_total_follows_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && out_free && emit_total_q |=> state_q == ST_CLEAR)
		else $error("total item not followed by the clearing pass");

endmodule
